### src/bss_pkg.sv
`default_nettype none
package bss_pkg;

  // Fixed field widths of the configuration registers
  localparam int unsigned LEN_FIELD_W = 5;
  localparam int unsigned GS_FIELD_W  = 4;
  // Width used for the small pattern-position arithmetic (gap start plus gap length)
  localparam int unsigned SW          = 6;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_ADDR_W  = 6;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned GAP_VALUE_BYTES = 8;

  typedef enum logic [2:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_GAP_START      = 3'd3,
    REG_GAP_LENGTH     = 3'd4,
    REG_WIDE_POINTERS  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [63:0]            pattern_low;
    logic [63:0]            pattern_high;
    logic [LEN_FIELD_W-1:0] pattern_length;
    logic [GS_FIELD_W-1:0]  gap_start;
    logic [LEN_FIELD_W-1:0] gap_length;
    logic                   wide_pointers;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [63:0] resolved_address;
  } out_item_t;

  // One classified byte, handed from the scan front to the address back end
  typedef struct packed {
    logic        hit;
    logic        last;
    logic [63:0] value;
    logic [63:0] offset;
  } scan_evt_t;

endpackage
`default_nettype wire

### src/bss_front.sv
`default_nettype none
module bss_front #(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned POSITION_BITS     = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bss_pkg::cfg_t      cfg,
  input  wire logic               push,
  input  wire bss_pkg::in_item_t  in_data,
  input  wire logic               q_full,
  output logic                    full,
  output logic                    evt_wr,
  output bss_pkg::scan_evt_t      evt
);

  localparam int unsigned IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam int unsigned SW    = bss_pkg::SW;

  logic [7:0]               win_r   [MAX_PATTERN_BYTES];
  logic [7:0]               win_nxt [MAX_PATTERN_BYTES];
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_inc, offset;
  logic [SW-1:0]            len6, gs6, ge6, gn6, ge_raw;
  logic [127:0]             pat;
  logic [63:0]              gap_value;
  logic                     accept, sat, mismatch, hit;

  assign accept = push && !q_full;
  assign full   = q_full;
  assign pat    = {cfg.pattern_high, cfg.pattern_low};

  always_comb begin
    win_nxt[0] = in_data.data_byte;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  // Effective window and gap bounds, all clipped to the window
  always_comb begin
    if (cfg.pattern_length == '0) begin
      len6 = SW'(1);
    end else if (SW'(cfg.pattern_length) > SW'(MAX_PATTERN_BYTES)) begin
      len6 = SW'(MAX_PATTERN_BYTES);
    end else begin
      len6 = SW'(cfg.pattern_length);
    end
    ge_raw = SW'(cfg.gap_start) + SW'(cfg.gap_length);
    gs6    = (SW'(cfg.gap_start) > len6) ? len6 : SW'(cfg.gap_start);
    ge6    = (ge_raw > len6) ? len6 : ge_raw;
    gn6    = ((ge6 - gs6) > SW'(bss_pkg::GAP_VALUE_BYTES)) ?
             SW'(bss_pkg::GAP_VALUE_BYTES) : (ge6 - gs6);
  end

  // Pattern byte i lines up with the byte received len-1-i bytes ago
  always_comb begin
    logic [SW-1:0] idx;
    mismatch = 1'b0;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      idx = len6 - SW'(1) - SW'(i);
      if ((SW'(i) < len6) && !((SW'(i) >= gs6) && (SW'(i) < ge6))) begin
        if (win_nxt[idx[IDX_W-1:0]] != pat[8*i +: 8]) begin
          mismatch = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [SW-1:0] idx;
    gap_value = '0;
    for (int j = 0; j < bss_pkg::GAP_VALUE_BYTES; j++) begin
      idx = len6 - SW'(1) - gs6 - SW'(j);
      if (SW'(j) < gn6) begin
        gap_value[8*j +: 8] = win_nxt[idx[IDX_W-1:0]];
      end
    end
  end

  assign sat     = &pos_r;
  assign pos_inc = pos_r + POSITION_BITS'(1);
  assign pos_nxt = sat ? pos_r : pos_inc;
  assign hit     = !sat && (pos_inc >= POSITION_BITS'(len6)) && !mismatch;
  assign offset  = pos_inc - POSITION_BITS'(len6) + POSITION_BITS'(gs6);

  assign evt_wr     = accept;
  assign evt.hit    = hit;
  assign evt.last   = in_data.last_byte;
  assign evt.value  = gap_value;
  assign evt.offset = 64'(offset);

  // Window bytes need no clear: only bytes newer than the position count are ever read
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= in_data.last_byte ? '0 : pos_nxt;
    end
  end

endmodule
`default_nettype wire

### src/bss_queue.sv
`default_nettype none
module bss_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire bss_pkg::scan_evt_t wr_data,
  input  wire logic               rd_en,
  output logic                    full,
  output logic                    empty,
  output bss_pkg::scan_evt_t      rd_data
);

  localparam int unsigned DEPTH = bss_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bss_pkg::scan_evt_t slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr_en || rd_en) else $error("queue write while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !rd_en) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule
`default_nettype wire

### src/bss_back.sv
`default_nettype none
module bss_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wide_pointers,
  input  wire logic               q_empty,
  input  wire bss_pkg::scan_evt_t q_data,
  output logic                    q_rd,
  output logic                    empty,
  input  wire logic               pop,
  output bss_pkg::out_item_t      out_data
);

  logic        seen_r, seen_nxt;
  logic [63:0] sum_r, sum_nxt;
  logic        out_valid_r;
  logic        res_found_r;
  logic [63:0] res_sum_r;
  logic        out_pop, slot_free, take, capture;

  assign out_pop   = pop && out_valid_r;
  assign slot_free = !out_valid_r || out_pop;
  // Only a last-byte transaction needs the result slot
  assign q_rd      = !q_empty && (!q_data.last || slot_free);
  assign take      = q_rd;
  assign capture   = take && q_data.hit && !seen_r;

  always_comb begin
    seen_nxt = seen_r;
    sum_nxt  = sum_r;
    if (capture) begin
      seen_nxt = 1'b1;
      sum_nxt  = q_data.value + q_data.offset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      sum_r  <= '0;
    end else if (take) begin
      seen_r <= q_data.last ? 1'b0 : seen_nxt;
      sum_r  <= q_data.last ? '0 : sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && q_data.last) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_data.last) begin
      res_found_r <= seen_nxt;
      res_sum_r   <= sum_nxt;
    end
  end

  assign empty = !out_valid_r;
  assign out_data.found = res_found_r;
  // Pointer-size adjustment: add the sum's low bits (mod 4 or mod 8)
  assign out_data.resolved_address =
    res_sum_r + {61'd0, res_sum_r[2] & wide_pointers, res_sum_r[1:0]};

  a_slot_free_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (take && q_data.last) |-> slot_free) else $error("result slot overwritten");
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (take && q_data.last) |=> (!seen_r && sum_r == '0)) else $error("scan not cleared");
  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_found_r) |-> res_sum_r == '0) else $error("miss with address");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !pop) |=> (out_valid_r && $stable(res_sum_r)))
    else $error("pending result changed");

endmodule
`default_nettype wire

### src/byte_signature_scanner_unit.sv
// Byte signature scanner.
// Input queue side: present one image byte per transaction on in_data with push;
// a transaction is taken at a clock edge where push is high and full is low.
// in_data.last_byte marks the final byte of an image. Result queue side: a result
// waits on out_data while empty is low and is taken with pop. One result per
// image, produced by the last byte: found and the resolved address (0 on miss).
// Throughput: one byte per cycle while full is low, set by the combinational masked
// window compare in the front stage. Result path after the last byte is taken: front
// classification into a two-entry queue, then the address adder in the back stage
// loading the result register.
// When the result register is held by a stalled receiver, bytes keep flowing
// until a last byte that cannot retire sits at the queue head and the queue fills; then full rises.
// Reset (rst_n low, synchronous) empties the queue, drops any pending result,
// clears the scan state and loads register defaults (pattern length 1, no gap,
// 8-byte pointers). Registers are written over the APB port at byte address 8*i
// and should only change while the block is idle.
`default_nettype none
module byte_signature_scanner_unit #(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned POSITION_BITS     = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             push,
  output logic                                  full,
  input  wire bss_pkg::in_item_t                in_data,
  output logic                                  empty,
  input  wire logic                             pop,
  output bss_pkg::out_item_t                    out_data,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bss_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [bss_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bss_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready
);

  bss_pkg::cfg_t      cfg_r;
  bss_pkg::scan_evt_t evt, q_data;
  bss_pkg::reg_idx_t  reg_idx;
  logic               evt_wr, q_full, q_empty, q_rd, cfg_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = bss_pkg::reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low    <= '0;
      cfg_r.pattern_high   <= '0;
      cfg_r.pattern_length <= bss_pkg::LEN_FIELD_W'(1);
      cfg_r.gap_start      <= '0;
      cfg_r.gap_length     <= '0;
      cfg_r.wide_pointers  <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bss_pkg::REG_PATTERN_LOW:    cfg_r.pattern_low    <= pwdata;
        bss_pkg::REG_PATTERN_HIGH:   cfg_r.pattern_high   <= pwdata;
        bss_pkg::REG_PATTERN_LENGTH: cfg_r.pattern_length <= pwdata[bss_pkg::LEN_FIELD_W-1:0];
        bss_pkg::REG_GAP_START:      cfg_r.gap_start      <= pwdata[bss_pkg::GS_FIELD_W-1:0];
        bss_pkg::REG_GAP_LENGTH:     cfg_r.gap_length     <= pwdata[bss_pkg::LEN_FIELD_W-1:0];
        bss_pkg::REG_WIDE_POINTERS:  cfg_r.wide_pointers  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bss_pkg::REG_PATTERN_LOW:    prdata = cfg_r.pattern_low;
      bss_pkg::REG_PATTERN_HIGH:   prdata = cfg_r.pattern_high;
      bss_pkg::REG_PATTERN_LENGTH: prdata = 64'(cfg_r.pattern_length);
      bss_pkg::REG_GAP_START:      prdata = 64'(cfg_r.gap_start);
      bss_pkg::REG_GAP_LENGTH:     prdata = 64'(cfg_r.gap_length);
      bss_pkg::REG_WIDE_POINTERS:  prdata = 64'(cfg_r.wide_pointers);
      default:                     prdata = '0;
    endcase
  end

  bss_front #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .POSITION_BITS     (POSITION_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .push    (push),
    .in_data (in_data),
    .q_full  (q_full),
    .full    (full),
    .evt_wr  (evt_wr),
    .evt     (evt)
  );

  bss_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (evt_wr),
    .wr_data (evt),
    .rd_en   (q_rd),
    .full    (q_full),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  bss_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .wide_pointers (cfg_r.wide_pointers),
    .q_empty       (q_empty),
    .q_data        (q_data),
    .q_rd          (q_rd),
    .empty         (empty),
    .pop           (pop),
    .out_data      (out_data)
  );

endmodule
`default_nettype wire
